/* sv/cts_pkg.sv */
// Shared types and constants for the cooldown task scheduler.
// No dependencies; imported by the scheduler top level.
`timescale 1ns / 1ps

package cts_pkg;

  localparam int ID_W = 8;
  localparam int CD_W = 8;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ADD   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  typedef struct packed {
    logic               en;
    logic [ID_W-1:0]    addr;
  } wr_ctl_t;

endpackage

/* sv/cts_count_mem.sv */
// Pending count memory: one write port, one registered read port.
// Per-entry valid flops make unwritten entries read as zero after reset.
// Depends on cts_pkg for the write control struct.
`timescale 1ns / 1ps

module cts_count_mem
  import cts_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_count,
  input  wr_ctl_t       wr_ctl,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [DW-1:0]    rd_data;
  logic             rd_vld;
  logic [AW-1:0]    wa;

  assign wa = wr_ctl.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_ctl.en) begin
      mem[wa] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_ctl.en) begin
        vld[wa] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  assign rd_count = rd_vld ? rd_data : '0;

endmodule

/* sv/cooldown_task_scheduler.sv */
// Cooldown task scheduler top level: control sequencer, round state, output register.
// Depends on cts_pkg and cts_count_mem.
//
//  channel | signals                        | direction | moves
//  input   | in_valid in_stall func task_id | in        | add or tick request
//  output  | out_valid out_stall slot_task  | out       | one result per tick
//          | idle done_res                  |           |
//  config  | cfg_valid cfg_ready cooldown   | in        | cooldown register write
//
// An add reads the count, then writes it back. A tick makes one memory read per task
// entry through the single read port, drains the read latency while it weighs the last
// entry, then updates the winner's count and loads the result.
// Reset clears the per-entry valid flops at once, so no clearing pass is needed.
// A stalled output holds the finishing tick until the result register frees up.
`timescale 1ns / 1ps

module cooldown_task_scheduler
  import cts_pkg::*;
#(
  parameter int NUM_TASKS   = 256,
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            func,
  input  logic [ID_W-1:0] task_id,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [ID_W-1:0] slot_task,
  output logic            idle,
  output logic            done_res,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CD_W-1:0] cooldown
);

  localparam int IW = $clog2(NUM_TASKS);
  localparam int MW = COUNT_WIDTH + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  state_t                 state;
  logic [CD_W-1:0]        cd_reg;
  logic [CD_W-1:0]        round_slot;
  logic                   clr_pend;
  logic [IW-1:0]          add_id;
  logic                   add_ok;
  logic [IW-1:0]          scan_idx;
  logic                   p_vld;
  logic [IW-1:0]          p_idx;
  logic                   any_work;
  logic                   found;
  logic [IW-1:0]          best_idx;
  logic [COUNT_WIDTH-1:0] best_cnt;

  logic [IW-1:0]          rd_addr;
  logic [MW-1:0]          rd_word;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic                   rd_ran;
  wr_ctl_t                wr_ctl;
  logic [MW-1:0]          wr_data;
  logic                   in_acc;
  logic                   out_free;
  logic                   take;

  // Each memory word holds the ran-this-round flag above the pending count. A round end
  // marks all flags stale, and the next scan writes the stale ones back as zero.
  assign rd_count  = rd_word[COUNT_WIDTH-1:0];
  assign rd_ran    = rd_word[COUNT_WIDTH] && !clr_pend;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign take      = p_vld && !rd_ran && (rd_count > best_cnt);

  always_comb begin
    case (state)
      S_SCAN:  rd_addr = scan_idx;
      default: rd_addr = task_id[IW-1:0];
    endcase
  end

  always_comb begin
    wr_ctl  = '0;
    wr_data = '0;
    case (state)
      S_ADD: begin
        wr_ctl.en   = add_ok && (rd_count != CNT_MAX);
        wr_ctl.addr = ID_W'(add_id);
        wr_data     = {rd_ran, rd_count + 1'b1};
      end
      S_SCAN, S_DRAIN: begin
        wr_ctl.en   = p_vld && clr_pend && rd_word[COUNT_WIDTH];
        wr_ctl.addr = ID_W'(p_idx);
        wr_data     = {1'b0, rd_count};
      end
      S_FIN: begin
        wr_ctl.en   = out_free && found;
        wr_ctl.addr = ID_W'(best_idx);
        wr_data     = {1'b1, best_cnt - 1'b1};
      end
      default: begin
        wr_ctl = '0;
      end
    endcase
  end

  cts_count_mem #(
    .DEPTH (NUM_TASKS),
    .AW    (IW),
    .DW    (MW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_count (rd_word),
    .wr_ctl   (wr_ctl),
    .wr_data  (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cd_reg     <= '0;
      round_slot <= '0;
      clr_pend   <= 1'b0;
      out_valid  <= 1'b0;
      p_vld      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cd_reg <= cooldown;
      end
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (func == FUNC_ADD) begin
              state <= S_ADD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_ADD: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          p_vld <= 1'b1;
          if (scan_idx == IW'(NUM_TASKS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          p_vld <= 1'b0;
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
            if (!any_work || (round_slot >= cd_reg)) begin
              clr_pend   <= 1'b1;
              round_slot <= '0;
            end else begin
              clr_pend   <= 1'b0;
              round_slot <= round_slot + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      add_id   <= task_id[IW-1:0];
      add_ok   <= ({1'b0, task_id} < (ID_W + 1)'(NUM_TASKS));
      scan_idx <= '0;
      any_work <= 1'b0;
      found    <= 1'b0;
      best_idx <= '0;
      best_cnt <= '0;
    end else begin
      if (state == S_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
        p_idx    <= scan_idx;
      end
      if (p_vld && (rd_count != '0)) begin
        any_work <= 1'b1;
      end
      if (take) begin
        found    <= 1'b1;
        best_idx <= p_idx;
        best_cnt <= rd_count;
      end
    end
    if ((state == S_FIN) && out_free) begin
      slot_task <= found ? ID_W'(best_idx) : '0;
      idle      <= any_work && !found;
      done_res  <= !any_work;
    end
  end

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(idle && done_res))
    else $error("result flags both idle and done");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (func == FUNC_TICK)) |=> (in_stall && (state == S_SCAN)))
    else $error("tick request did not start a scan");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIN) && out_free) |=> (out_valid && (state == S_IDLE)))
    else $error("finished tick did not load the result register");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIN) && out_free && !any_work) |=> (clr_pend && (round_slot == '0)))
    else $error("done slot did not start a fresh round");

endmodule
